// File: rtl/bst_pkg.sv
// Shared types and constants for the bit-pair serial transceiver.
// No dependencies; imported by every module of the block.
package bst_pkg;

  // Register map (byte address = 4 * index)
  localparam int unsigned RegCount = 3;
  localparam logic [1:0] REG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] REG_RX_OFFSET    = 2'd1;
  localparam logic [1:0] REG_TX_OFFSET    = 2'd2;

  localparam logic [7:0] TICKS_PER_US_RST = 8'd8;
  localparam logic [3:0] RX_OFFSET_RST    = 4'd3;
  localparam logic [3:0] TX_OFFSET_RST    = 4'd3;

  // Commands carried in tuser
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_RX   = 2'd1;
  localparam logic [1:0] FUNC_TX   = 2'd2;

  // Protocol delays in microseconds
  localparam logic [4:0] US_RX_FIRST = 5'd13;
  localparam logic [4:0] US_RX_PAIR  = 5'd13;
  localparam logic [4:0] US_RX_SHORT = 5'd11;
  localparam logic [4:0] US_RX_END   = 5'd6;
  localparam logic [4:0] US_TX_FIRST = 5'd6;
  localparam logic [4:0] US_TX_PAIR  = 5'd10;
  localparam logic [4:0] US_TX_LONG  = 5'd11;
  localparam logic [4:0] US_ONE      = 5'd1;

  localparam logic [6:0] LOAD_SKIP_MASK = 7'h7f;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  typedef struct packed {
    logic [7:0] ticks_per_us;
    logic [3:0] rx_offset;
    logic [3:0] tx_offset;
  } bst_cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] send_byte;
    logic       send_eoi;
    logic [7:0] load_flags;
    logic       atn_level;
    logic       clock_level;
    logic       data_level;
  } bst_item_t;

  typedef struct packed {
    logic       send_result;
    logic [2:0] bus_snapshot;
    logic [7:0] received_byte;
    logic       done_res;
    logic       busy_res;
    logic       data_drive;
    logic       clock_drive;
  } bst_res_t;

  typedef enum logic [16:0] {
    PH_IDLE    = 17'h00001,
    PH_RX_WAIT = 17'h00002,
    PH_RX_P0   = 17'h00004,
    PH_RX_P1   = 17'h00008,
    PH_RX_P2   = 17'h00010,
    PH_RX_P3   = 17'h00020,
    PH_RX_SNAP = 17'h00040,
    PH_RX_END  = 17'h00080,
    PH_TX_SETL = 17'h00100,
    PH_TX_WAIT = 17'h00200,
    PH_TX_P0   = 17'h00400,
    PH_TX_P1   = 17'h00800,
    PH_TX_P2   = 17'h01000,
    PH_TX_P3   = 17'h02000,
    PH_TX_EOI  = 17'h04000,
    PH_TX_HOLD = 17'h08000,
    PH_TX_END  = 17'h10000
  } bst_phase_t;

endpackage

// File: rtl/bst_core.sv
// Protocol sequencer: phase register, microsecond timer and shift byte.
// Depends on bst_pkg for item, result, configuration and phase types.
module bst_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bst_pkg::bst_cfg_t  cfg,
  input  bst_pkg::bst_item_t item,
  output bst_pkg::bst_res_t  res
);
  import bst_pkg::*;

  bst_phase_t phase, phase_next;
  logic [7:0] tick_count, tick_count_next;
  logic [4:0] micro_count, micro_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       eoi_flag, eoi_flag_next;
  logic [7:0] load_flag_saved, load_flag_saved_next;
  logic [2:0] wait_pattern, wait_pattern_next;
  logic [1:0] line_drive, line_drive_next;
  logic [7:0] rx_byte, rx_byte_next;
  logic [2:0] snapshot, snapshot_next;
  logic       send_result, send_result_next;

  logic [7:0] lim, tc_inc, tc_run;
  logic [4:0] mc_run;
  logic       tc_wrap, fire, timed, done;
  logic [2:0] lines;

  always_comb begin
    lim     = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
    tc_inc  = tick_count + 8'd1;
    tc_wrap = (tc_inc >= lim);
    tc_run  = tc_wrap ? 8'd0 : tc_inc;
    fire    = tc_wrap && (micro_count <= 5'd1);
    if (!tc_wrap) begin
      mc_run = micro_count;
    end else if (micro_count <= 5'd1) begin
      mc_run = 5'd0;
    end else begin
      mc_run = micro_count - 5'd1;
    end
    lines = {item.data_level, item.clock_level, item.atn_level};
    timed = (phase != PH_IDLE) && (phase != PH_RX_WAIT) &&
            (phase != PH_TX_WAIT) && (phase != PH_TX_END);

    phase_next           = phase;
    tick_count_next      = timed ? tc_run : tick_count;
    micro_count_next     = timed ? mc_run : micro_count;
    shift_byte_next      = shift_byte;
    eoi_flag_next        = eoi_flag;
    load_flag_saved_next = load_flag_saved;
    wait_pattern_next    = wait_pattern;
    line_drive_next      = line_drive;
    rx_byte_next         = rx_byte;
    snapshot_next        = snapshot;
    send_result_next     = send_result;
    done                 = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.func == FUNC_RX) begin
          line_drive_next = 2'b11;
          shift_byte_next = 8'd0;
          phase_next      = PH_RX_WAIT;
        end else if (item.func == FUNC_TX) begin
          line_drive_next      = 2'b11;
          shift_byte_next      = ~item.send_byte;
          eoi_flag_next        = item.send_eoi;
          load_flag_saved_next = item.load_flags;
          wait_pattern_next    = (item.load_flags != 8'd0) ? 3'd7 : 3'd3;
          micro_count_next     = US_ONE;
          tick_count_next      = 8'd0;
          phase_next           = PH_TX_SETL;
        end
      end
      PH_RX_WAIT: begin
        if (item.clock_level) begin
          micro_count_next = US_RX_FIRST + {1'b0, cfg.rx_offset};
          tick_count_next  = 8'd0;
          phase_next       = PH_RX_P0;
        end else if (!item.atn_level) begin
          line_drive_next = {1'b0, line_drive[0]};
        end
      end
      PH_RX_P0: begin
        if (fire) begin
          shift_byte_next  = shift_byte | {2'b00, item.data_level, item.clock_level, 4'd0};
          micro_count_next = US_RX_PAIR;
          tick_count_next  = 8'd0;
          phase_next       = PH_RX_P1;
        end
      end
      PH_RX_P1: begin
        if (fire) begin
          shift_byte_next  = shift_byte | {item.data_level, item.clock_level, 6'd0};
          micro_count_next = US_RX_SHORT;
          tick_count_next  = 8'd0;
          phase_next       = PH_RX_P2;
        end
      end
      PH_RX_P2: begin
        if (fire) begin
          shift_byte_next  = shift_byte |
                             {4'd0, item.clock_level, 1'b0, item.data_level, 1'b0};
          micro_count_next = US_RX_PAIR;
          tick_count_next  = 8'd0;
          phase_next       = PH_RX_P3;
        end
      end
      PH_RX_P3: begin
        if (fire) begin
          shift_byte_next  = shift_byte |
                             {5'd0, item.clock_level, 1'b0, item.data_level};
          micro_count_next = US_RX_PAIR;
          tick_count_next  = 8'd0;
          phase_next       = PH_RX_SNAP;
        end
      end
      PH_RX_SNAP: begin
        if (fire) begin
          snapshot_next    = lines;
          micro_count_next = US_RX_END;
          tick_count_next  = 8'd0;
          phase_next       = PH_RX_END;
        end
      end
      PH_RX_END: begin
        if (fire) begin
          line_drive_next = {1'b0, line_drive[0]};
          rx_byte_next    = ~shift_byte;
          done            = 1'b1;
          phase_next      = PH_IDLE;
        end
      end
      PH_TX_SETL: begin
        if (fire) begin
          phase_next = PH_TX_WAIT;
        end
      end
      PH_TX_WAIT: begin
        if (lines != wait_pattern) begin
          micro_count_next = US_TX_FIRST + {1'b0, cfg.tx_offset};
          tick_count_next  = 8'd0;
          phase_next       = PH_TX_P0;
        end
      end
      PH_TX_P0, PH_TX_P1, PH_TX_P2: begin
        if (fire) begin
          line_drive_next = shift_byte[1:0];
          shift_byte_next = {2'b00, shift_byte[7:2]};
          tick_count_next = 8'd0;
          if (phase == PH_TX_P0) begin
            micro_count_next = US_TX_PAIR;
            phase_next       = PH_TX_P1;
          end else if (phase == PH_TX_P1) begin
            micro_count_next = US_TX_LONG;
            phase_next       = PH_TX_P2;
          end else begin
            micro_count_next = US_TX_PAIR;
            phase_next       = PH_TX_P3;
          end
        end
      end
      PH_TX_P3: begin
        if (fire) begin
          line_drive_next = shift_byte[1:0];
          shift_byte_next = {2'b00, shift_byte[7:2]};
          // load mode with any of the low seven flags set skips the end mark
          if ((load_flag_saved[6:0] & LOAD_SKIP_MASK) != 7'd0) begin
            send_result_next = 1'b0;
            done             = 1'b1;
            phase_next       = PH_IDLE;
          end else begin
            micro_count_next = US_TX_LONG;
            tick_count_next  = 8'd0;
            phase_next       = PH_TX_EOI;
          end
        end
      end
      PH_TX_EOI: begin
        if (fire) begin
          line_drive_next  = eoi_flag ? 2'b10 : 2'b01;
          micro_count_next = US_ONE;
          tick_count_next  = 8'd0;
          phase_next       = PH_TX_HOLD;
        end
      end
      PH_TX_HOLD: begin
        if (fire) begin
          phase_next = PH_TX_END;
        end
      end
      PH_TX_END: begin
        if (!(item.atn_level && item.data_level)) begin
          send_result_next = ~item.atn_level;
          done             = 1'b1;
          phase_next       = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    res.clock_drive   = line_drive_next[0];
    res.data_drive    = line_drive_next[1];
    res.busy_res      = (phase_next != PH_IDLE);
    res.done_res      = done;
    res.received_byte = rx_byte_next;
    res.bus_snapshot  = snapshot_next;
    res.send_result   = send_result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_count      <= 8'd0;
      micro_count     <= 5'd0;
      shift_byte      <= 8'd0;
      eoi_flag        <= 1'b0;
      load_flag_saved <= 8'd0;
      wait_pattern    <= 3'd0;
      line_drive      <= 2'b11;
      rx_byte         <= 8'd0;
      snapshot        <= 3'd0;
      send_result     <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      micro_count     <= micro_count_next;
      shift_byte      <= shift_byte_next;
      eoi_flag        <= eoi_flag_next;
      load_flag_saved <= load_flag_saved_next;
      wait_pattern    <= wait_pattern_next;
      line_drive      <= line_drive_next;
      rx_byte         <= rx_byte_next;
      snapshot        <= snapshot_next;
      send_result     <= send_result_next;
    end
  end

endmodule

// File: rtl/bst_out_buf.sv
// Two-entry result buffer between the sequencer and the output stream.
// Depends on bst_pkg for the result type.
module bst_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bst_pkg::bst_res_t push_data,
  output logic             space,
  input  logic             pop,
  output logic             avail,
  output bst_pkg::bst_res_t head
);
  import bst_pkg::*;

  bst_res_t   slot0, slot1;
  logic [1:0] count;

  assign space = (count != 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // payload: land a new word in the first free slot, else advance on pop
  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      slot0 <= push_data;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      slot1 <= push_data;
    end
  end

endmodule

// File: rtl/bitpair_serial_transceiver.sv
// Top level of the bit-pair serial transceiver: stream ports, APB registers.
// Depends on bst_pkg, bst_core and bst_out_buf.
//
// Each input word is one tick of bus timing: it carries the sampled attention,
// clock and data levels and, in tuser, a command (tick only, start receive,
// start send). Every accepted word yields exactly one result word holding the
// requested clock/data drive levels, busy and done flags and the latest
// receive byte, bus snapshot and send result. The block takes one word every
// clock cycle unless both buffer entries are full; the sequencer updates its
// phase, microsecond timer and shift byte in the cycle of acceptance and
// writes the result into a two-entry output buffer, so the input keeps
// flowing while up to two results wait for the downstream side. Input
// tready drops only when both buffer entries are full. Protocol timing is
// counted in accepted words, ticks_per_microsecond of them per microsecond
// (zero acts as one). Registers: 0x0 ticks_per_microsecond (8 bit, reset 8),
// 0x4 receive_offset_us (4 bit, reset 3), 0x8 send_offset_us (4 bit, reset 3);
// write them only while no transfer is running.
module bitpair_serial_transceiver (
  input  logic        clk,
  input  logic        rst,
  // tdata: send_byte[7:0], send_eoi[8], load_flags[16:9], atn_level[17],
  //        clock_level[18], data_level[19], zero pad [23:20]
  input  logic [23:0] s_tdata,
  // tuser: func[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: clock_drive[0], data_drive[1], busy_res[2], done_res[3],
  //        received_byte[11:4], bus_snapshot[14:12], send_result[15]
  output logic [15:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bst_pkg::*;

  bst_cfg_t  cfg;
  bst_item_t item;
  bst_res_t  res, head;
  logic      step, space, avail, cfg_wr;
  logic [1:0] reg_idx;

  // APB: zero wait states, decode on the word index
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_us <= TICKS_PER_US_RST;
      cfg.rx_offset    <= RX_OFFSET_RST;
      cfg.tx_offset    <= TX_OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TICKS_PER_US: cfg.ticks_per_us <= pwdata[7:0];
        REG_RX_OFFSET:    cfg.rx_offset    <= pwdata[3:0];
        REG_TX_OFFSET:    cfg.tx_offset    <= pwdata[3:0];
        default:          cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TICKS_PER_US: prdata = {24'd0, cfg.ticks_per_us};
      REG_RX_OFFSET:    prdata = {28'd0, cfg.rx_offset};
      REG_TX_OFFSET:    prdata = {28'd0, cfg.tx_offset};
      default:          prdata = 32'd0;
    endcase
  end

  // unpack the incoming word
  always_comb begin
    item.func        = s_tuser;
    item.send_byte   = s_tdata[7:0];
    item.send_eoi    = s_tdata[8];
    item.load_flags  = s_tdata[16:9];
    item.atn_level   = s_tdata[17];
    item.clock_level = s_tdata[18];
    item.data_level  = s_tdata[19];
  end

  // advance the sequencer on every accepted word
  assign s_tready = space;
  assign step     = s_tvalid && space;

  bst_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .item (item),
    .res  (res)
  );

  bst_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (res),
    .space     (space),
    .pop       (m_tvalid && m_tready),
    .avail     (avail),
    .head      (head)
  );

  assign m_tvalid = avail;
  assign m_tdata  = {head.send_result, head.bus_snapshot, head.received_byte,
                     head.done_res, head.busy_res, head.data_drive, head.clock_drive};

endmodule

// File: verif/bst_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Line-level predictor and result store for the bit-pair serial transceiver bench.
// Depends on bst_pkg for the word, result and phase types and the protocol delays.
package bst_scoreboard_pkg;
  import bst_pkg::*;

  class bst_scoreboard;
    // registers as last written
    logic [7:0] tpu;
    logic [3:0] rx_off;
    logic [3:0] tx_off;

    // transceiver state
    bst_phase_t phase;
    logic [7:0] tick_cnt;
    logic [4:0] us_cnt;
    logic [7:0] shreg;
    logic       eoi;
    logic [7:0] load_saved;
    logic [2:0] wait_pat;
    logic [1:0] drive;        // bit0 clock, bit1 data
    logic [7:0] rx_byte;
    logic [2:0] snap;
    logic       send_res;

    bst_res_t tick_reports[$];
    int errors;
    int words;
    int rx_bytes;
    int tx_bytes;

    function new();
      tpu = TICKS_PER_US_RST;
      rx_off = RX_OFFSET_RST;
      tx_off = TX_OFFSET_RST;
      phase = PH_IDLE;
      tick_cnt = '0;
      us_cnt = '0;
      shreg = '0;
      eoi = 1'b0;
      load_saved = '0;
      wait_pat = '0;
      drive = 2'b11;
      rx_byte = '0;
      snap = '0;
      send_res = 1'b0;
      errors = 0;
      words = 0;
      rx_bytes = 0;
      tx_bytes = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_TICKS_PER_US: tpu = val[7:0];
        REG_RX_OFFSET:    rx_off = val[3:0];
        REG_TX_OFFSET:    tx_off = val[3:0];
        default: ;
      endcase
    endfunction

    function void arm(int us);
      us_cnt = (us == 0) ? 5'd1 : us[4:0];
      tick_cnt = '0;
    endfunction

    // count one tick; true once the armed delay has run out
    function bit expired();
      logic [7:0] lim;
      lim = (tpu == 8'd0) ? 8'd1 : tpu;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= lim) begin
        tick_cnt = '0;
        if (us_cnt <= 5'd1) begin
          us_cnt = '0;
          return 1'b1;
        end
        us_cnt = us_cnt - 5'd1;
      end
      return 1'b0;
    endfunction

    function void drive_pair();
      drive = shreg[1:0];
      shreg = shreg >> 2;
    endfunction

    function bst_res_t tick_transceiver(bst_item_t it);
      logic [2:0] lines;
      logic       done;
      bst_res_t   r;
      lines = {it.data_level, it.clock_level, it.atn_level};
      done = 1'b0;
      case (phase)
        PH_IDLE: begin
          if (it.func == FUNC_RX) begin
            drive = 2'b11;
            shreg = '0;
            phase = PH_RX_WAIT;
          end else if (it.func == FUNC_TX) begin
            drive = 2'b11;
            shreg = ~it.send_byte;
            eoi = it.send_eoi;
            load_saved = it.load_flags;
            wait_pat = (it.load_flags != 8'd0) ? 3'b111 : 3'b011;
            arm(int'(US_ONE));
            phase = PH_TX_SETL;
          end
        end
        PH_RX_WAIT: begin
          if (it.clock_level) begin
            arm(int'(US_RX_FIRST) + int'(rx_off));
            phase = PH_RX_P0;
          end else if (!it.atn_level) begin
            drive[1] = 1'b0;
          end
        end
        PH_RX_P0: if (expired()) begin
          shreg[5:4] = {it.data_level, it.clock_level};
          arm(int'(US_RX_PAIR));
          phase = PH_RX_P1;
        end
        PH_RX_P1: if (expired()) begin
          shreg[7:6] = {it.data_level, it.clock_level};
          arm(int'(US_RX_SHORT));
          phase = PH_RX_P2;
        end
        PH_RX_P2: if (expired()) begin
          shreg[1] = it.data_level;
          shreg[3] = it.clock_level;
          arm(int'(US_RX_PAIR));
          phase = PH_RX_P3;
        end
        PH_RX_P3: if (expired()) begin
          shreg[0] = it.data_level;
          shreg[2] = it.clock_level;
          arm(int'(US_RX_PAIR));
          phase = PH_RX_SNAP;
        end
        PH_RX_SNAP: if (expired()) begin
          snap = lines;
          arm(int'(US_RX_END));
          phase = PH_RX_END;
        end
        PH_RX_END: if (expired()) begin
          drive[1] = 1'b0;
          rx_byte = ~shreg;
          done = 1'b1;
          rx_bytes++;
          phase = PH_IDLE;
        end
        PH_TX_SETL: if (expired()) phase = PH_TX_WAIT;
        PH_TX_WAIT: begin
          if (lines != wait_pat) begin
            arm(int'(US_TX_FIRST) + int'(tx_off));
            phase = PH_TX_P0;
          end
        end
        PH_TX_P0: if (expired()) begin
          drive_pair();
          arm(int'(US_TX_PAIR));
          phase = PH_TX_P1;
        end
        PH_TX_P1: if (expired()) begin
          drive_pair();
          arm(int'(US_TX_LONG));
          phase = PH_TX_P2;
        end
        PH_TX_P2: if (expired()) begin
          drive_pair();
          arm(int'(US_TX_PAIR));
          phase = PH_TX_P3;
        end
        PH_TX_P3: if (expired()) begin
          drive_pair();
          if ((load_saved[6:0] & LOAD_SKIP_MASK) != 7'd0) begin
            send_res = 1'b0;
            done = 1'b1;
            tx_bytes++;
            phase = PH_IDLE;
          end else begin
            arm(int'(US_TX_LONG));
            phase = PH_TX_EOI;
          end
        end
        PH_TX_EOI: if (expired()) begin
          // end mark: clock low for the last byte, else data low
          drive = eoi ? 2'b10 : 2'b01;
          arm(int'(US_ONE));
          phase = PH_TX_HOLD;
        end
        PH_TX_HOLD: if (expired()) phase = PH_TX_END;
        PH_TX_END: begin
          if (!(it.atn_level && it.data_level)) begin
            send_res = ~it.atn_level;
            done = 1'b1;
            tx_bytes++;
            phase = PH_IDLE;
          end
        end
        default: phase = PH_IDLE;
      endcase
      r.clock_drive = drive[0];
      r.data_drive = drive[1];
      r.busy_res = (phase != PH_IDLE);
      r.done_res = done;
      r.received_byte = rx_byte;
      r.bus_snapshot = snap;
      r.send_result = send_res;
      return r;
    endfunction

    function void note_word(bst_item_t it);
      words++;
      tick_reports.push_back(tick_transceiver(it));
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [15:0] raw);
      bst_res_t got;
      bst_res_t want;
      got = raw;
      if (tick_reports.size() == 0) begin
        $error("result word 0x%0h arrived with nothing awaited", raw);
        errors++;
        return;
      end
      want = tick_reports.pop_front();
      compare_field("clock_drive", want.clock_drive, got.clock_drive);
      compare_field("data_drive", want.data_drive, got.data_drive);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("received_byte", want.received_byte, got.received_byte);
      compare_field("bus_snapshot", want.bus_snapshot, got.bus_snapshot);
      compare_field("send_result", want.send_result, got.send_result);
    endfunction
  endclass

endpackage

// File: verif/bitpair_serial_transceiver_test.sv
`timescale 1ns / 1ps
// Self-checking bench for bitpair_serial_transceiver: random bus ticks and transfers.
// Depends on bst_pkg and bst_scoreboard_pkg (line-level predictor and result store).
module bitpair_serial_transceiver_test;
  import bst_pkg::*;
  import bst_scoreboard_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;   // decoded as tick only
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 4;            // settling wait after the awaited results are in
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 60;
  localparam int MODE_WORDS    = 100;          // rough word budget per idling mode

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = FUNC_TICK;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bst_scoreboard sb = new();

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int stall_reqs = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int cycles = 0;

  bitpair_serial_transceiver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Hard stop: a hung handshake or a transfer that never ends lands here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check every accepted result word, then pick the next tready.
  // A requested hold-off is counted here so the sender keeps pushing meanwhile
  // and the two-entry output buffer fills up and stalls the input.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      stall_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offer one word, idling first at the current rate; note it once accepted.
  task automatic put_word(input bst_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.func;
    s_tdata <= {4'b0000, it.data_level, it.clock_level, it.atn_level,
                it.load_flags, it.send_eoi, it.send_byte};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(it);
  endtask

  // Random word carrying no command (tick only, or the unused code).
  function automatic bst_item_t idle_word();
    logic [31:0] r;
    bst_item_t   it;
    r = $urandom;
    it = r[21:0];
    it.func = $urandom_range(1) ? FUNC_UNUSED : FUNC_TICK;
    return it;
  endfunction

  // Word for a tick inside a transfer. Commands here must be ignored; steer
  // the line levels so that the line-condition waits neither stall for ever
  // nor always end on the first tick.
  function automatic bst_item_t busy_word();
    logic [31:0] r;
    bst_item_t   it;
    r = $urandom;
    it = r[21:0];
    if ($urandom_range(1)) it.func = FUNC_TICK;
    case (sb.phase)
      PH_RX_WAIT: it.clock_level = ($urandom_range(3) == 0);
      PH_TX_WAIT:
        if ($urandom_range(2) != 0)
          {it.data_level, it.clock_level, it.atn_level} = sb.wait_pat;
      PH_TX_END:
        if ($urandom_range(2) != 0) begin
          it.atn_level = 1'b1;
          it.data_level = 1'b1;
        end
      default: ;
    endcase
    return it;
  endfunction

  // Issue a command word and keep the bus ticking until the transfer ends.
  task automatic run_transfer(input bst_item_t start);
    put_word(start);
    while (sb.phase != PH_IDLE) put_word(busy_word());
  endtask

  task automatic random_transfer();
    bst_item_t it;
    it = idle_word();
    it.func = $urandom_range(1) ? FUNC_RX : FUNC_TX;
    // plain wait pattern with end mark, all-high wait with end mark, or skip
    case ($urandom_range(3))
      0: it.load_flags = 8'h00;
      1: it.load_flags = 8'h80;
      default: ;
    endcase
    repeat ($urandom_range(4)) put_word(idle_word());
    run_transfer(it);
  endtask

  // Drop valid and wait until every awaited result is in, then let the output settle.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (sb.tick_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, val);
  endtask

  task automatic apply_setting(input logic [7:0] tpu, input logic [3:0] rx_off,
                               input logic [3:0] tx_off);
    write_reg(REG_TICKS_PER_US, {24'd0, tpu});
    write_reg(REG_RX_OFFSET, {28'd0, rx_off});
    write_reg(REG_TX_OFFSET, {28'd0, tx_off});
  endtask

  initial begin
    bst_item_t  it;
    logic [7:0] tpu_set[3];
    logic [3:0] rx_set[3];
    logic [3:0] tx_set[3];
    int         drain;
    int         budget;

    // short microseconds keep transfers brief; offsets swing between extremes
    tpu_set = '{8'd1, 8'd2, 8'd1};
    rx_set  = '{4'd15, 4'd0, 4'd7};
    tx_set  = '{4'd0, 4'd15, 4'd3};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Ignored command codes at the reset register values.
    it = '1;
    it.func = FUNC_UNUSED;
    put_word(it);
    it = '0;
    put_word(it);

    // Directed part: zero ticks per microsecond acts as one.
    wait_quiet();
    apply_setting(8'd0, 4'd0, 4'd0);
    // receive with every other field at its top value
    it = '1;
    it.func = FUNC_RX;
    run_transfer(it);
    // last byte, all-high wait pattern: end mark pulls clock low
    it = '0;
    it.func = FUNC_TX;
    it.send_eoi = 1'b1;
    it.load_flags = 8'h80;
    run_transfer(it);
    // load mode skips the end mark entirely
    it = '0;
    it.func = FUNC_TX;
    it.send_byte = 8'h5a;
    it.load_flags = 8'h7f;
    run_transfer(it);

    // Random part: three idling modes, one register setting in each.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin src_idle_pct = 26; snk_idle_pct = 73; end
        1: begin src_idle_pct = 73; snk_idle_pct = 26; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      wait_quiet();
      apply_setting(tpu_set[mode], rx_set[mode], tx_set[mode]);
      stall_reqs++;
      budget = sb.words + MODE_WORDS;
      do begin
        random_transfer();
      end while (sb.words < budget);
    end

    // Drain, bounded, then let any stray results show up.
    s_tvalid <= 1'b0;
    drain = 0;
    while (sb.tick_reports.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.tick_reports.size() != 0) begin
      $error("%0d result words never arrived", sb.tick_reports.size());
      sb.errors++;
    end

    $display("Covered %0d bus ticks: %0d bytes received, %0d sent,", sb.words,
             sb.rx_bytes, sb.tx_bytes);
    $display("tick rates 0 to 2, offsets 0 to 15, commands while busy, stalls on either side.");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bst_pkg.sv
rtl/bst_core.sv
rtl/bst_out_buf.sv
rtl/bitpair_serial_transceiver.sv
verif/bst_scoreboard_pkg.sv
verif/bitpair_serial_transceiver_test.sv
